// ----- hw/rtl/dnm_pkg.sv -----
`timescale 1ns / 1ps
package dnm_pkg;

	localparam int MAX_POINTS = 64;
	localparam int DESC_DIM   = 128;

	// entry index, element index, count and address widths
	localparam int IW  = $clog2(MAX_POINTS);
	localparam int KW  = $clog2(DESC_DIM);
	localparam int CW  = $clog2(MAX_POINTS + 1);
	localparam int AW  = IW + KW;
	// squared distance: 16-bit squares summed over DESC_DIM elements
	localparam int DW  = 16 + KW;
	localparam int PW  = DW + 16;

	typedef enum logic [1:0] {
		KIND_ELEM  = 2'd0,
		KIND_POINT = 2'd1,
		KIND_START = 2'd2,
		KIND_NONE  = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		REG_COUNT_A  = 3'd0,
		REG_COUNT_B  = 3'd1,
		REG_RATIO_EN = 3'd2,
		REG_CROSS_EN = 3'd3,
		REG_RATIO_SQ = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [6:0]  count_a;
		logic [6:0]  count_b;
		logic        ratio_enable;
		logic        cross_enable;
		logic [15:0] ratio_sq;
	} cfg_t;

	// one decoded input item as queued between front and back
	typedef struct packed {
		kind_t       kind;
		logic        set_sel;
		logic [5:0]  entry_index;
		logic [6:0]  elem_index;
		logic [7:0]  elem_value;
		logic [15:0] point_x;
		logic [15:0] point_y;
	} cmd_t;

	typedef struct packed {
		logic        valid;
		cmd_t        cmd;
	} cmdq_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_NN_RUN,
		ST_NN_DRAIN,
		ST_RATIO_MUL,
		ST_RATIO_CMP,
		ST_CROSS_RUN,
		ST_CROSS_DRAIN,
		ST_PT_WAIT,
		ST_EMIT,
		ST_NEXT,
		ST_FINAL
	} st_t;

endpackage

// ----- hw/rtl/dnm_front.sv -----
`timescale 1ns / 1ps
module dnm_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [55:0]         s_tdata,
	input  logic [2:0]          s_tuser,
	output dnm_pkg::cmdq_t      q_out,
	input  logic                q_pop
);
	import dnm_pkg::*;

	cmd_t       fifo_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;
	cmd_t       in_cmd;
	logic       push, pop;

	// unpack the item into its fields
	always_comb begin
		in_cmd.kind        = kind_t'(s_tuser[1:0]);
		in_cmd.set_sel     = s_tuser[2];
		in_cmd.entry_index = s_tdata[5:0];
		in_cmd.elem_index  = s_tdata[12:6];
		in_cmd.elem_value  = s_tdata[20:13];
		in_cmd.point_x     = s_tdata[36:21];
		in_cmd.point_y     = s_tdata[52:37];
	end

	assign s_tready  = (cnt_q != 2'd2);
	assign push      = s_tvalid && s_tready;
	assign pop       = q_pop && (cnt_q != 2'd0);
	assign q_out.valid = (cnt_q != 2'd0);
	assign q_out.cmd   = fifo_q[rd_q];

	// two-entry item queue
	always_ff @(posedge clk) begin
		if (push) fifo_q[wr_q] <= in_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	a_cnt_max: assert property (@(posedge clk) disable iff (!arst_n) cnt_q != 2'd3)
		else $error("queue count overflow");
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd2) |-> !s_tready)
		else $error("accepting while full");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd1) |-> (wr_q != rd_q))
		else $error("pointer mismatch");

endmodule

// ----- hw/rtl/dnm_back.sv -----
`timescale 1ns / 1ps
module dnm_back (
	input  logic                clk,
	input  logic                arst_n,
	input  dnm_pkg::cfg_t       cfg,
	input  dnm_pkg::cmdq_t      q_in,
	output logic                q_pop,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [79:0]         m_tdata,
	output logic                m_tuser,
	output logic                m_tlast
);
	import dnm_pkg::*;

	localparam logic [KW-1:0] K_LAST = KW'(DESC_DIM - 1);

	st_t state_q, state_d;

	// stores
	logic [7:0]  desc_a [MAX_POINTS*DESC_DIM];
	logic [7:0]  desc_b [MAX_POINTS*DESC_DIM];
	logic [31:0] pt_a [MAX_POINTS];
	logic [31:0] pt_b [MAX_POINTS];

	logic [CW-1:0] na, nb, lim;
	logic [CW-1:0] i_q, j_q;
	logic [KW-1:0] k_q;
	logic          issue, cross_run, elem_last, vec_last, run_done, pipe_busy;
	logic [AW-1:0] addr_a, addr_b, waddr;
	logic          wr_da, wr_db, wr_pa, wr_pb, start;
	logic          load_ok;

	// distance pipeline
	logic          v_s1, last_s1, first_s1, cross_s1;
	logic [IW-1:0] idx_s1;
	logic [7:0]    rd_a_s1, rd_b_s1;
	logic          v_s2, last_s2, first_s2, cross_s2;
	logic [IW-1:0] idx_s2;
	logic [15:0]   sq_s2;
	logic [DW-1:0] acc_q, acc_nxt;
	logic          v_s3, cross_s3;
	logic [IW-1:0] idx_s3;
	logic [DW-1:0] dist_s3;
	logic signed [8:0] diff;

	// nearest tracking
	logic          have_best_q, have_second_q, have_c_q;
	logic [DW-1:0] bd_q, sd_q, cd_q;
	logic [IW-1:0] bi_q, ci_q;
	logic [PW-1:0] prod_q;

	// result registers
	logic [31:0]   pa_rd_q, pb_rd_q;
	logic          out_valid_q, out_found_q, out_last_q, out_free;
	logic [75:0]   out_data_q;
	logic          pend_valid_q;
	logic [75:0]   pend_data_q;
	logic [75:0]   new_data;

	assign na = (cfg.count_a > CW'(MAX_POINTS)) ? CW'(MAX_POINTS) : cfg.count_a[CW-1:0];
	assign nb = (cfg.count_b > CW'(MAX_POINTS)) ? CW'(MAX_POINTS) : cfg.count_b[CW-1:0];

	assign cross_run = (state_q == ST_CROSS_RUN);
	assign issue     = (state_q == ST_NN_RUN) || cross_run;
	assign lim       = cross_run ? na : nb;
	assign elem_last = (k_q == K_LAST);
	assign vec_last  = (j_q == lim - CW'(1));
	assign run_done  = issue && elem_last && vec_last;
	assign pipe_busy = v_s1 || v_s2 || v_s3;
	assign out_free  = !out_valid_q || m_tready;

	assign addr_a = cross_run ? {j_q[IW-1:0], k_q} : {i_q[IW-1:0], k_q};
	assign addr_b = cross_run ? {bi_q, k_q} : {j_q[IW-1:0], k_q};

	// load decode
	assign start   = (state_q == ST_IDLE) && q_in.valid && (q_in.cmd.kind == KIND_START);
	assign load_ok = (state_q == ST_IDLE) && q_in.valid
		&& (7'(q_in.cmd.entry_index) < 7'(MAX_POINTS));
	assign waddr   = {q_in.cmd.entry_index[IW-1:0], q_in.cmd.elem_index[KW-1:0]};
	assign wr_da   = load_ok && (q_in.cmd.kind == KIND_ELEM) && !q_in.cmd.set_sel
		&& (9'(q_in.cmd.elem_index) < 9'(DESC_DIM));
	assign wr_db   = load_ok && (q_in.cmd.kind == KIND_ELEM) && q_in.cmd.set_sel
		&& (9'(q_in.cmd.elem_index) < 9'(DESC_DIM));
	assign wr_pa   = load_ok && (q_in.cmd.kind == KIND_POINT) && !q_in.cmd.set_sel;
	assign wr_pb   = load_ok && (q_in.cmd.kind == KIND_POINT) && q_in.cmd.set_sel;
	assign q_pop   = (state_q == ST_IDLE) && q_in.valid;

	// descriptor memories: one write, one registered read each
	always_ff @(posedge clk) begin
		if (wr_da) desc_a[waddr] <= q_in.cmd.elem_value;
		rd_a_s1 <= desc_a[addr_a];
	end

	always_ff @(posedge clk) begin
		if (wr_db) desc_b[waddr] <= q_in.cmd.elem_value;
		rd_b_s1 <= desc_b[addr_b];
	end

	// keypoint memories
	always_ff @(posedge clk) begin
		if (wr_pa) pt_a[q_in.cmd.entry_index[IW-1:0]] <= {q_in.cmd.point_x, q_in.cmd.point_y};
		pa_rd_q <= pt_a[i_q[IW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (wr_pb) pt_b[q_in.cmd.entry_index[IW-1:0]] <= {q_in.cmd.point_x, q_in.cmd.point_y};
		pb_rd_q <= pt_b[bi_q];
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (na == '0) state_d = ST_FINAL;
					else if (nb == '0) state_d = ST_NEXT;
					else state_d = ST_NN_RUN;
				end
			end
			ST_NN_RUN: if (run_done) state_d = ST_NN_DRAIN;
			ST_NN_DRAIN: begin
				if (!pipe_busy) begin
					if (!have_best_q) state_d = ST_NEXT;
					else if (cfg.ratio_enable)
						state_d = have_second_q ? ST_RATIO_MUL : ST_NEXT;
					else if (cfg.cross_enable) state_d = ST_CROSS_RUN;
					else state_d = ST_PT_WAIT;
				end
			end
			ST_RATIO_MUL: state_d = ST_RATIO_CMP;
			ST_RATIO_CMP: begin
				if ({bd_q, 16'h0} >= prod_q) state_d = ST_NEXT;
				else if (cfg.cross_enable) state_d = ST_CROSS_RUN;
				else state_d = ST_PT_WAIT;
			end
			ST_CROSS_RUN: if (run_done) state_d = ST_CROSS_DRAIN;
			ST_CROSS_DRAIN: begin
				if (!pipe_busy) state_d = (CW'(ci_q) == i_q) ? ST_PT_WAIT : ST_NEXT;
			end
			ST_PT_WAIT: state_d = ST_EMIT;
			ST_EMIT: if (!pend_valid_q || out_free) state_d = ST_NEXT;
			ST_NEXT: begin
				if (i_q == na - CW'(1)) state_d = ST_FINAL;
				else if (nb == '0) state_d = ST_NEXT;
				else state_d = ST_NN_RUN;
			end
			ST_FINAL: if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// loop counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q <= '0;
			j_q <= '0;
			k_q <= '0;
		end else begin
			if (start) i_q <= '0;
			else if (state_q == ST_NEXT) i_q <= i_q + CW'(1);
			if (issue) begin
				if (elem_last) begin
					k_q <= '0;
					j_q <= vec_last ? '0 : j_q + CW'(1);
				end else begin
					k_q <= k_q + KW'(1);
				end
			end else begin
				j_q <= '0;
				k_q <= '0;
			end
		end
	end

	// distance pipeline: read, square, accumulate
	assign diff    = $signed({1'b0, rd_a_s1}) - $signed({1'b0, rd_b_s1});
	assign acc_nxt = (first_s2 ? DW'(0) : acc_q) + DW'(sq_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2 && last_s2;
		end
	end

	always_ff @(posedge clk) begin
		last_s1  <= elem_last;
		first_s1 <= (k_q == '0);
		cross_s1 <= cross_run;
		idx_s1   <= j_q[IW-1:0];
		sq_s2    <= 16'(diff * diff);
		last_s2  <= last_s1;
		first_s2 <= first_s1;
		cross_s2 <= cross_s1;
		idx_s2   <= idx_s1;
		if (v_s2) acc_q <= acc_nxt;
		dist_s3  <= acc_nxt;
		cross_s3 <= cross_s2;
		idx_s3   <= idx_s2;
		prod_q   <= PW'(cfg.ratio_sq) * PW'(sd_q);
	end

	// nearest and second-nearest tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_best_q   <= 1'b0;
			have_second_q <= 1'b0;
			have_c_q      <= 1'b0;
		end else begin
			if (state_q == ST_IDLE || state_q == ST_NEXT) begin
				have_best_q   <= 1'b0;
				have_second_q <= 1'b0;
			end else if (v_s3 && !cross_s3) begin
				if (!have_best_q || dist_s3 < bd_q) begin
					have_best_q   <= 1'b1;
					have_second_q <= have_best_q;
				end else begin
					have_second_q <= 1'b1;
				end
			end
			if (state_q != ST_CROSS_RUN && state_q != ST_CROSS_DRAIN) have_c_q <= 1'b0;
			else if (v_s3 && cross_s3 && (!have_c_q || dist_s3 < cd_q)) have_c_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s3 && !cross_s3) begin
			if (!have_best_q || dist_s3 < bd_q) begin
				bd_q <= dist_s3;
				bi_q <= idx_s3;
				if (have_best_q) sd_q <= bd_q;
			end else if (!have_second_q || dist_s3 < sd_q) begin
				sd_q <= dist_s3;
			end
		end
		if (v_s3 && cross_s3 && (!have_c_q || dist_s3 < cd_q)) begin
			cd_q <= dist_s3;
			ci_q <= idx_s3;
		end
	end

	// result: one held back so the final one can carry last
	assign new_data = {pb_rd_q[15:0], pb_rd_q[31:16], pa_rd_q[15:0], pa_rd_q[31:16],
		bi_q, i_q[IW-1:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			pend_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_EMIT) begin
				if (!pend_valid_q) pend_valid_q <= 1'b1;
			end else if (state_q == ST_FINAL && out_free) begin
				pend_valid_q <= 1'b0;
			end
			if ((state_q == ST_EMIT && pend_valid_q && out_free)
				|| (state_q == ST_FINAL && out_free))
				out_valid_q <= 1'b1;
			else if (out_valid_q && m_tready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT) begin
			if (!pend_valid_q) begin
				pend_data_q <= new_data;
			end else if (out_free) begin
				out_data_q  <= pend_data_q;
				out_found_q <= 1'b1;
				out_last_q  <= 1'b0;
				pend_data_q <= new_data;
			end
		end else if (state_q == ST_FINAL && out_free) begin
			out_data_q  <= pend_valid_q ? pend_data_q : '0;
			out_found_q <= pend_valid_q;
			out_last_q  <= 1'b1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'h0, out_data_q};
	assign m_tuser  = out_found_q;
	assign m_tlast  = out_last_q;

	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (!pipe_busy && !pend_valid_q))
		else $error("work left over in idle");
	a_second: assert property (@(posedge clk) disable iff (!arst_n)
		have_second_q |-> have_best_q)
		else $error("second nearest without nearest");
	a_nofind_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_found_q) |-> out_last_q)
		else $error("empty result not final");
	a_cross_tag: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && cross_s1) |-> $past(cross_run))
		else $error("pass tag mismatch");

endmodule

// ----- hw/rtl/descriptor_nn_matcher_top.sv -----
`timescale 1ns / 1ps
// channel | handshake          | payload
// s       | s_tvalid/s_tready  | s_tdata {point_y,point_x,elem_value,elem_index,entry_index}
//         |                    | s_tuser {set_sel,kind}
// m       | m_tvalid/m_tready  | m_tdata {dst_y,dst_x,src_y,src_x,dst_index,src_index}
//         |                    | m_tuser found, m_tlast last
// cfg     | cfg_we             | cfg_index, cfg_data
//
// Loads pass through a two-entry queue into the stores.
// A start walks every pair one descriptor element per cycle on the single read
// port of each descriptor memory; the cross pass runs only when enabled, for entries
// that have a nearest and, with the ratio test enabled, pass it.
// Reset sets control state and cfg defaults; the stores hold garbage until written.
// A stalled m side holds the engine at its next result; loads queue meanwhile.
module descriptor_nn_matcher_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,   // entry_index, elem_index, elem_value, point_x, point_y
	input  logic [2:0]  s_tuser,   // kind, set_sel
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata,   // src_index, dst_index, src_x, src_y, dst_x, dst_y
	output logic        m_tuser,   // found
	output logic        m_tlast,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import dnm_pkg::*;

	cfg_t   cfg_q;
	cmdq_t  q;
	logic   q_pop;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.count_a      <= 7'd64;
			cfg_q.count_b      <= 7'd64;
			cfg_q.ratio_enable <= 1'b1;
			cfg_q.cross_enable <= 1'b1;
			cfg_q.ratio_sq     <= 16'd10486;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_COUNT_A:  cfg_q.count_a      <= cfg_data[6:0];
				REG_COUNT_B:  cfg_q.count_b      <= cfg_data[6:0];
				REG_RATIO_EN: cfg_q.ratio_enable <= cfg_data[0];
				REG_CROSS_EN: cfg_q.cross_enable <= cfg_data[0];
				REG_RATIO_SQ: cfg_q.ratio_sq     <= cfg_data;
				default: ;
			endcase
		end
	end

	dnm_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_out    (q),
		.q_pop    (q_pop)
	);

	dnm_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_in     (q),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule
